>>> design/lbpc_pkg.sv
// ----------------------------------------------------------------------------
// lbpc_pkg: shared types and constants for the ladder button press classifier
// Register indexes, reset values, press kinds, phase codes and ladder
// thresholds.
// ----------------------------------------------------------------------------
package lbpc_pkg;

  localparam int unsigned NumButtonsDef = 8;
  localparam int unsigned MaxButtons    = 16;

  localparam int unsigned SampleW = 10;
  localparam int unsigned MarginW = 8;
  localparam int unsigned TickW   = 5;
  localparam int unsigned ButtonW = 5;
  localparam int unsigned KindW   = 2;

  // sample plus margin needs one extra bit
  localparam int unsigned SumW    = SampleW + 1;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;

  typedef logic [SampleW-1:0] sample_t;
  typedef logic [MarginW-1:0] margin_t;
  typedef logic [TickW-1:0]   tick_t;
  typedef logic [ButtonW-1:0] button_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  typedef enum logic [KindW-1:0] {
    KIND_MOMENTARY = 2'd0,
    KIND_DOUBLE    = 2'd1,
    KIND_LONG      = 2'd2,
    KIND_ALTERNATE = 2'd3
  } kind_t;

  localparam cfg_idx_t REG_IDLE_CUTOFF  = 3'd0;
  localparam cfg_idx_t REG_MATCH_MARGIN = 3'd1;
  localparam cfg_idx_t REG_LONG_PRESS   = 3'd2;
  localparam cfg_idx_t REG_HOLD_LIMIT   = 3'd3;
  localparam cfg_idx_t REG_GAP_LIMIT    = 3'd4;
  localparam cfg_idx_t REG_DOUBLE_GAP   = 3'd5;

  localparam sample_t RST_IDLE_CUTOFF  = 10'd1000;
  localparam margin_t RST_MATCH_MARGIN = 8'd15;
  localparam tick_t   RST_LONG_PRESS   = 5'd10;
  localparam tick_t   RST_HOLD_LIMIT   = 5'd20;
  localparam tick_t   RST_GAP_LIMIT    = 5'd10;
  localparam tick_t   RST_DOUBLE_GAP   = 5'd7;

  localparam tick_t TICK_MAX = '1;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_FIRST = 6'b000010,
    PH_HOLD  = 6'b000100,
    PH_GAP   = 6'b001000,
    PH_REL1  = 6'b010000,
    PH_REL2  = 6'b100000
  } phase_t;

  // floor(1024*i/(10+i)) for each ladder position
  typedef sample_t thresh_tbl_t [MaxButtons];
  localparam thresh_tbl_t LADDER_THRESH = '{
    10'd0,   10'd93,  10'd170, 10'd236, 10'd292, 10'd341, 10'd384, 10'd421,
    10'd455, 10'd485, 10'd512, 10'd536, 10'd558, 10'd578, 10'd597, 10'd614
  };

endpackage

>>> design/lbpc_decode.sv
// ----------------------------------------------------------------------------
// lbpc_decode: ladder sample to button number
// Returns 0 above the idle cutoff, otherwise the highest ladder position whose
// threshold lies below sample + margin, numbered from 1.
// ----------------------------------------------------------------------------
module lbpc_decode
  import lbpc_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = NumButtonsDef
) (
  input  sample_t sample,
  input  sample_t idle_cutoff,
  input  margin_t match_margin,
  output button_t button
);

  logic [SumW-1:0] sum;
  logic [NUM_BUTTONS-1:0] hit;

  assign sum = {1'b0, sample} + {{(SumW-MarginW){1'b0}}, match_margin};

  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      hit[i] = sum > {1'b0, LADDER_THRESH[i]};
    end
  end

  // highest hit wins; with no hit at all the ladder reads as button 1
  always_comb begin
    button = ButtonW'(1);
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (hit[i]) begin
        button = ButtonW'(i + 1);
      end
    end
    if (sample > idle_cutoff) begin
      button = '0;
    end
  end

endmodule

>>> design/ladder_button_press_classifier.sv
// ----------------------------------------------------------------------------
// ladder_button_press_classifier: resistor ladder keypad press classifier
// Settles ADC samples, decodes the ladder and reports long, double,
// momentary or alternate-button presses.
// ----------------------------------------------------------------------------
// One sample is taken every cycle while in_tready is high. An
// accepted sample lands in an input register; once it can move on it is decoded
// and the press state updated in a single pass, and any press report is loaded
// into the output register. A sample that yields no report
// moves on even while a report waits at the output; a sample that yields one
// waits in the input register until the output register is free. Samples only
// count when equal to the previous one, and a new press is taken only after
// two no-button readings. Configuration is written through cfg_* and takes
// effect for the next sample.
module ladder_button_press_classifier
  import lbpc_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = NumButtonsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  // in_tdata: [9:0] sample
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [15:0]         in_tdata,
  // out_tdata: [1:0] press_kind, [6:2] button, [11:7] alt_button
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  cfg_idx_t            cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  // configuration
  sample_t idle_cutoff_r;
  margin_t match_margin_r;
  tick_t   long_press_r, hold_limit_r, gap_limit_r, double_gap_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_cutoff_r  <= RST_IDLE_CUTOFF;
      match_margin_r <= RST_MATCH_MARGIN;
      long_press_r   <= RST_LONG_PRESS;
      hold_limit_r   <= RST_HOLD_LIMIT;
      gap_limit_r    <= RST_GAP_LIMIT;
      double_gap_r   <= RST_DOUBLE_GAP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IDLE_CUTOFF:  idle_cutoff_r  <= cfg_data[SampleW-1:0];
        REG_MATCH_MARGIN: match_margin_r <= cfg_data[MarginW-1:0];
        REG_LONG_PRESS:   long_press_r   <= cfg_data[TickW-1:0];
        REG_HOLD_LIMIT:   hold_limit_r   <= cfg_data[TickW-1:0];
        REG_GAP_LIMIT:    gap_limit_r    <= cfg_data[TickW-1:0];
        REG_DOUBLE_GAP:   double_gap_r   <= cfg_data[TickW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic    s1_valid_r;
  sample_t s1_sample_r;
  logic    advance;

  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_sample_r <= in_tdata[SampleW-1:0];
    end
  end

  // press state
  sample_t prev_sample_r;
  logic    prev_valid_r;
  phase_t  phase_r, phase_nxt;
  button_t held_r, held_nxt;
  tick_t   hold_r, hold_nxt, gap_r, gap_nxt;

  button_t rd;
  logic    settled, emit, do_gap, is_alt;
  kind_t   kind;
  button_t alt;

  lbpc_decode #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_decode (
    .sample       (s1_sample_r),
    .idle_cutoff  (idle_cutoff_r),
    .match_margin (match_margin_r),
    .button       (rd)
  );

  assign settled = prev_valid_r && (s1_sample_r == prev_sample_r);
  assign is_alt  = (rd != '0) && (rd < held_r);

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    hold_nxt  = hold_r;
    gap_nxt   = gap_r;
    emit      = 1'b0;
    do_gap    = 1'b0;
    kind      = KIND_MOMENTARY;
    alt       = '0;
    if (settled) begin
      case (phase_r)
        PH_IDLE: begin
          if (rd != '0) begin
            held_nxt  = rd;
            hold_nxt  = '0;
            gap_nxt   = '0;
            phase_nxt = PH_FIRST;
          end
        end
        PH_FIRST: begin
          if (rd == held_r && hold_r < hold_limit_r) begin
            phase_nxt = PH_HOLD;
          end else begin
            do_gap = 1'b1;
          end
        end
        PH_HOLD: begin
          if (is_alt) begin
            emit = 1'b1;
            kind = KIND_ALTERNATE;
            alt  = rd;
          end else begin
            if (hold_r != TICK_MAX) begin
              hold_nxt = hold_r + tick_t'(1);
            end
            if (!(rd == held_r && hold_nxt < hold_limit_r)) begin
              do_gap = 1'b1;
            end
          end
        end
        PH_GAP: begin
          if (is_alt) begin
            emit = 1'b1;
            kind = KIND_ALTERNATE;
            alt  = rd;
          end else begin
            if (gap_r != TICK_MAX) begin
              gap_nxt = gap_r + tick_t'(1);
            end
            do_gap = 1'b1;
          end
        end
        PH_REL1: begin
          if (rd == '0) begin
            phase_nxt = PH_REL2;
          end
        end
        PH_REL2: begin
          if (rd == '0) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase

      // release gap: keep counting on no-button below the gap limit, else classify now
      if (do_gap) begin
        if (rd == '0 && gap_nxt < gap_limit_r) begin
          phase_nxt = PH_GAP;
        end else begin
          emit = 1'b1;
          if (hold_nxt > long_press_r) begin
            kind = KIND_LONG;
          end else if (gap_nxt < double_gap_r) begin
            kind = KIND_DOUBLE;
          end else begin
            kind = KIND_MOMENTARY;
          end
        end
      end
      if (emit) begin
        phase_nxt = PH_REL1;
      end
    end
  end

  // output register
  logic    out_valid_r;
  kind_t   out_kind_r;
  button_t out_button_r, out_alt_r;

  assign advance = s1_valid_r && (!out_valid_r || out_tready || !emit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_sample_r <= '0;
      prev_valid_r  <= 1'b0;
      phase_r       <= PH_IDLE;
      held_r        <= '0;
      hold_r        <= '0;
      gap_r         <= '0;
    end else if (advance) begin
      prev_sample_r <= s1_sample_r;
      prev_valid_r  <= 1'b1;
      phase_r       <= phase_nxt;
      held_r        <= held_nxt;
      hold_r        <= hold_nxt;
      gap_r         <= gap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_kind_r   <= kind;
      out_button_r <= held_r;
      out_alt_r    <= alt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_alt_r, out_button_r, out_kind_r};

`ifndef ASSERT_OFF
  a_button_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_button_r != '0)
    else $error("press reported without a held button");

  a_alt_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_kind_r == KIND_ALTERNATE) ?
      (out_alt_r != '0 && out_alt_r < out_button_r) : (out_alt_r == '0)))
    else $error("alternate button field inconsistent with kind");

  a_emit_release: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && emit) |=> phase_r == PH_REL1 && out_valid_r)
    else $error("report not followed by release wait");

  a_unsettled_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !settled) |=> $stable(phase_r) && $stable(hold_r))
    else $error("unsettled sample changed press state");
`endif

endmodule

>>> sim/ladder_button_press_classifier_tb.sv
// ----------------------------------------------------------------------------
// ladder_button_press_classifier_tb: self-checking bench for the press classifier
// Drives ladder samples as press sequences and noise through several register
// settings, predicts every press report and compares it field by field.
// ----------------------------------------------------------------------------
module ladder_button_press_classifier_tb;
  import lbpc_pkg::*;

  localparam int NumBtn     = NumButtonsDef;
  localparam int HoldoffLen = 400;
  localparam int StallLimit = 4000;
  localparam int SettleWait = 8;

  // indexes that map to no register
  localparam cfg_idx_t REG_UNUSED_LO = 3'd6;
  localparam cfg_idx_t REG_UNUSED_HI = 3'd7;

  typedef struct packed {
    kind_t   kind;
    button_t button;
    button_t alt;
  } press_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [15:0]         in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [15:0]         out_tdata;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  cfg_idx_t            cfg_index  = '0;
  logic [CfgDataW-1:0] cfg_data   = '0;

  ladder_button_press_classifier dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // register shadow
  sample_t cut_q      = RST_IDLE_CUTOFF;
  margin_t margin_q   = RST_MATCH_MARGIN;
  tick_t   long_q     = RST_LONG_PRESS;
  tick_t   holdlim_q  = RST_HOLD_LIMIT;
  tick_t   gaplim_q   = RST_GAP_LIMIT;
  tick_t   dblgap_q   = RST_DOUBLE_GAP;

  // press tracker state
  sample_t last_sample = '0;
  logic    last_valid  = 1'b0;
  phase_t  ph          = PH_IDLE;
  button_t held_btn    = '0;
  tick_t   hold_cnt    = '0;
  tick_t   gap_cnt     = '0;

  sample_t sample_q [$];
  press_t  press_exp [$];

  int n_pushed     = 0;
  int in_taken     = 0;
  int fail_cnt     = 0;
  int stall_cnt    = 0;
  logic in_fired   = 1'b0;

  int tx_wait = 0, tx_calm = 0;
  int rx_wait = 0, rx_calm = 0;
  int holdoff_req = 0, holdoff_done = 0, rx_hold_left = 0;

  function automatic int ladder_floor(int i);
    return (1024 * i) / (10 + i);
  endfunction

  function automatic button_t ladder_decode(sample_t s);
    if (s > cut_q) return '0;
    for (int b = NumBtn; b > 0; b--)
      if (int'(s) + int'(margin_q) > ladder_floor(b - 1)) return button_t'(b);
    return button_t'(1);
  endfunction

  // mostly short gaps, a few long ones, and now and then a calm stretch
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 2) begin
      calm = $urandom_range(120, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic track_press(sample_t s);
    logic    settled;
    logic    do_gap;
    button_t r;
    press_t  p;
    settled = last_valid && (s == last_sample);
    last_sample = s;
    last_valid  = 1'b1;
    if (!settled) return;
    r = ladder_decode(s);
    do_gap = 1'b0;
    case (ph)
      PH_IDLE: begin
        if (r != 0) begin
          held_btn = r;
          hold_cnt = '0;
          gap_cnt  = '0;
          ph       = PH_FIRST;
        end
      end
      PH_FIRST: begin
        if (r == held_btn && hold_cnt < holdlim_q) ph = PH_HOLD;
        else do_gap = 1'b1;
      end
      PH_HOLD, PH_GAP: begin
        if (r >= 1 && r < held_btn) begin
          // lower button seen while the press is open
          p = '{kind: KIND_ALTERNATE, button: held_btn, alt: r};
          press_exp.push_back(p);
          ph = PH_REL1;
        end else if (ph == PH_HOLD) begin
          if (hold_cnt < TICK_MAX) hold_cnt++;
          if (!(r == held_btn && hold_cnt < holdlim_q)) do_gap = 1'b1;
        end else begin
          if (gap_cnt < TICK_MAX) gap_cnt++;
          do_gap = 1'b1;
        end
      end
      PH_REL1: if (r == 0) ph = PH_REL2;
      PH_REL2: if (r == 0) ph = PH_IDLE;
      default: ph = PH_IDLE;
    endcase
    if (do_gap) begin
      if (r == 0 && gap_cnt < gaplim_q) begin
        ph = PH_GAP;
      end else begin
        p.button = held_btn;
        p.alt    = '0;
        if (hold_cnt > long_q) p.kind = KIND_LONG;
        else if (gap_cnt < dblgap_q) p.kind = KIND_DOUBLE;
        else p.kind = KIND_MOMENTARY;
        press_exp.push_back(p);
        ph = PH_REL1;
      end
    end
  endtask

  // sample that decodes to the wanted button under the current registers, where one exists
  function automatic sample_t pick_sample(int target);
    int lo, hi;
    if (target == 0) begin
      if (cut_q == '1) return sample_t'($urandom_range(1023, 0));
      return sample_t'($urandom_range(1023, int'(cut_q) + 1));
    end
    lo = ladder_floor(target - 1) - int'(margin_q) + 1;
    if (lo < 0) lo = 0;
    hi = (target == NumBtn) ? int'(cut_q) : ladder_floor(target) - int'(margin_q);
    if (hi > int'(cut_q)) hi = int'(cut_q);
    if (lo > hi) return sample_t'($urandom_range(int'(cut_q), 0));
    return sample_t'($urandom_range(hi, lo));
  endfunction

  task automatic push_sample(sample_t s);
    sample_q.push_back(s);
    n_pushed++;
  endtask

  task automatic push_reading(int target);
    sample_t s;
    int reps;
    s = pick_sample(target);
    reps = ($urandom_range(9) == 0) ? 1 : (($urandom_range(4) == 0) ? 3 : 2);
    repeat (reps) push_sample(s);
  endtask

  task automatic gen_press();
    int b, n_hold, n_gap, alt_at, alt_b;
    b      = $urandom_range(NumBtn, 1);
    n_hold = $urandom_range(int'(holdlim_q) + 2, 0);
    n_gap  = $urandom_range(int'(gaplim_q) + 2, 0);
    alt_at = (b > 1 && $urandom_range(4) == 0) ? $urandom_range(n_hold + n_gap, 0) : -1;
    alt_b  = (b > 1) ? $urandom_range(b - 1, 1) : 1;
    for (int k = 0; k <= n_hold; k++) push_reading((k == alt_at) ? alt_b : b);
    for (int k = 0; k < n_gap; k++) push_reading((k + n_hold + 1 == alt_at) ? alt_b : 0);
    // second tap
    if ($urandom_range(2) == 0) repeat ($urandom_range(3, 1)) push_reading(b);
    push_reading(0);
    if ($urandom_range(4) == 0) push_reading($urandom_range(NumBtn, 1));
    push_reading(0);
  endtask

  task automatic run_phase(int n);
    int start;
    start = n_pushed;
    while (n_pushed - start < n) begin
      if ($urandom_range(4) != 0) gen_press();
      else repeat ($urandom_range(6, 1)) push_sample(sample_t'($urandom_range(1023, 0)));
    end
  endtask

  task automatic wait_drained();
    while (in_taken != n_pushed || press_exp.size() != 0) @(negedge clk);
    repeat (SettleWait) @(negedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, int val, int w);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    // bits above the register width are noise
    cfg_data  <= CfgDataW'(val | ($urandom << w));
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic cfg_all(int cut, int mg, int lp, int hl, int gl, int dg);
    cfg_write(REG_IDLE_CUTOFF,  cut, SampleW);
    cfg_write(REG_MATCH_MARGIN, mg,  MarginW);
    cfg_write(REG_LONG_PRESS,   lp,  TickW);
    cfg_write(REG_HOLD_LIMIT,   hl,  TickW);
    cfg_write(REG_GAP_LIMIT,    gl,  TickW);
    cfg_write(REG_DOUBLE_GAP,   dg,  TickW);
  endtask

  task automatic cfg_random();
    cfg_all($urandom_range(1023, 400), $urandom_range(255, 0), $urandom_range(31, 0),
            $urandom_range(31, 1), $urandom_range(31, 1), $urandom_range(31, 0));
  endtask

  // sample driver
  always @(negedge clk) begin : drv
    logic        nv;
    logic [15:0] nd;
    nv = in_tvalid;
    nd = in_tdata;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (!in_tvalid || in_fired) begin
      nv = 1'b0;
      if (tx_wait > 0) begin
        tx_wait--;
      end else if (sample_q.size() > 0) begin
        nv = 1'b1;
        nd = {{(16 - SampleW){1'b0}}, sample_q.pop_front()};
        tx_wait = idle_len(tx_calm);
      end
    end
    in_tvalid <= nv;
    in_tdata  <= nd;
  end

  // result receiver
  always @(negedge clk) begin : rx
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_tready <= 1'b0;
    end else if (holdoff_req != holdoff_done) begin
      holdoff_done = holdoff_req;
      rx_hold_left = HoldoffLen - 1;
      out_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      rx_wait = idle_len(rx_calm);
    end
  end

  always @(posedge clk) begin : mon
    press_t got, want;
    logic   any_fire;
    in_fired <= rst_n && in_tvalid && in_tready;
    if (!rst_n) begin
      stall_cnt <= 0;
    end else begin
      any_fire = (cfg_valid && cfg_ready) || (out_tvalid && out_tready) ||
                 (in_tvalid && in_tready);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IDLE_CUTOFF:  cut_q     = cfg_data[SampleW-1:0];
          REG_MATCH_MARGIN: margin_q  = cfg_data[MarginW-1:0];
          REG_LONG_PRESS:   long_q    = cfg_data[TickW-1:0];
          REG_HOLD_LIMIT:   holdlim_q = cfg_data[TickW-1:0];
          REG_GAP_LIMIT:    gaplim_q  = cfg_data[TickW-1:0];
          REG_DOUBLE_GAP:   dblgap_q  = cfg_data[TickW-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.kind   = kind_t'(out_tdata[1:0]);
        got.button = out_tdata[6:2];
        got.alt    = out_tdata[11:7];
        if (press_exp.size() == 0) begin
          if (fail_cnt < 10)
            $display("%0t: unexpected press report kind %0d button %0d alt %0d",
                     $realtime, got.kind, got.button, got.alt);
          fail_cnt++;
        end else begin
          want = press_exp.pop_front();
          if (got.kind !== want.kind || got.button !== want.button ||
              got.alt !== want.alt) begin
            if (fail_cnt < 10)
              $display("%0t: press report kind %0d button %0d alt %0d, expected %0d %0d %0d",
                       $realtime, got.kind, got.button, got.alt,
                       want.kind, want.button, want.alt);
            fail_cnt++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        track_press(in_tdata[SampleW-1:0]);
        in_taken++;
      end
      stall_cnt <= any_fire ? 0 : stall_cnt + 1;
    end
  end

  initial begin : watchdog
    while (stall_cnt < StallLimit) @(negedge clk);
    $display("FAIL ladder_button_press_classifier");
    $finish;
  end

  initial begin : stim
    sample_t directed [24] = '{
      10'd0, 10'd0, 10'd0, 10'd0, 10'd1023, 10'd1023, 10'd1023, 10'd1000,
      10'd1000, 10'd1001, 10'd1001, 10'd1001, 10'd512, 10'd512, 10'd300, 10'd300,
      10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'h2AA, 10'h155, 10'd1023, 10'd1023
    };
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: extremes of the sample first
    foreach (directed[i]) push_sample(directed[i]);
    run_phase(100);
    wait_drained();

    cfg_random();
    run_phase(110);
    wait_drained();

    // tightest limits, widest margin, only sample zero is a button
    cfg_all(0, 255, 0, 1, 1, 31);
    run_phase(110);
    wait_drained();

    // loosest limits, no no-button reading possible
    cfg_all(1023, 0, 31, 31, 31, 0);
    run_phase(60);
    wait_drained();

    // output held off while the press stream runs on
    cfg_all($urandom_range(1010, 900), $urandom_range(30, 0), $urandom_range(4, 0),
            $urandom_range(8, 1), $urandom_range(4, 1), $urandom_range(4, 0));
    run_phase(150);
    holdoff_req++;
    wait_drained();

    // zero limits skip hold and gap counting; spare indexes are ignored
    cfg_all(1000, 15, 5, 0, 0, 7);
    cfg_write(REG_UNUSED_LO, $urandom_range(1023, 0), 0);
    cfg_write(REG_UNUSED_HI, $urandom_range(1023, 0), 0);
    run_phase(110);
    wait_drained();

    cfg_random();
    run_phase(110);
    wait_drained();

    cfg_all(1000, 15, 10, 20, 10, 7);
    run_phase(110);
    wait_drained();

    if (fail_cnt == 0 && press_exp.size() == 0) begin
      $display("PASS ladder_button_press_classifier");
    end else begin
      $display("FAIL ladder_button_press_classifier");
    end
    $finish;
  end

endmodule
